### rtl/core/mtg_pkg.sv
// mtg_pkg: constants, control state type and word functions for the MT19937 core.
// Used by mtg_seed_step and mersenne_twister_generator_core; no dependencies.
`default_nettype none
package mtg_pkg;

    localparam int unsigned WORD_W = 32;

    // initialization recurrence and twist constants
    localparam logic [WORD_W-1:0] INIT_MULT  = 32'd1812433253;
    localparam logic [WORD_W-1:0] RESET_SEED = 32'd5489;
    localparam logic [WORD_W-1:0] TWIST_XOR  = 32'h9908_B0DF;
    localparam logic [WORD_W-1:0] UPPER_BIT  = 32'h8000_0000;
    localparam logic [WORD_W-1:0] LOWER_BITS = 32'h7FFF_FFFF;
    localparam int unsigned       INIT_SHIFT = 30;

    // tempering constants
    localparam logic [WORD_W-1:0] TEMPER_B = 32'h9D2C_5680;
    localparam logic [WORD_W-1:0] TEMPER_C = 32'hEFC6_0000;

    typedef logic [WORD_W-1:0] t_word;

    // op codes of an input transaction
    typedef enum logic {
        OP_DRAW = 1'b0,
        OP_SEED = 1'b1
    } t_op;

    // control state: filling the cell row or streaming draws
    typedef enum logic {
        ST_FILL = 1'b0,
        ST_RUN  = 1'b1
    } t_state;

    // one twist step from the current, next and middle words
    function automatic t_word f_twist(input t_word cur, input t_word nxt, input t_word mid);
        t_word y;
        t_word v;
        y = (cur & UPPER_BIT) | (nxt & LOWER_BITS);
        v = mid ^ (y >> 1);
        if (y[0]) begin
            v = v ^ TWIST_XOR;
        end
        return v;
    endfunction

    // output tempering
    function automatic t_word f_temper(input t_word w);
        t_word y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage
`default_nettype wire

### rtl/core/mtg_cell.sv
// mtg_cell: one state word of the generator's shift row.
// Loads its input word on every shift; no package dependency.
`default_nettype none
module mtg_cell #(
    parameter int unsigned WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_shift,
    input  wire logic [WIDTH-1:0] i_d,
    output logic      [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_word;

    // word storage, payload only
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_word <= i_d;
        end
    end

    assign o_q = r_word;

endmodule
`default_nettype wire

### rtl/core/mtg_seed_step.sv
// mtg_seed_step: one step of the seeding recurrence, s[i] = M * (s ^ (s >> 30)) + i.
// Depends on mtg_pkg for the multiplier constant and word type.
`default_nettype none
module mtg_seed_step #(
    parameter int unsigned IDX_W = 10
) (
    input  wire mtg_pkg::t_word   i_prev,
    input  wire logic [IDX_W-1:0] i_index,
    output mtg_pkg::t_word        o_next
);
    import mtg_pkg::*;

    t_word w_mix;
    t_word w_prod;

    // low half of the 32x32 product, then add the index
    assign w_mix  = i_prev ^ (i_prev >> INIT_SHIFT);
    assign w_prod = t_word'(w_mix * INIT_MULT);
    assign o_next = w_prod + WORD_W'(i_index);

endmodule
`default_nettype wire

### rtl/core/mersenne_twister_generator_core.sv
// mersenne_twister_generator_core: MT19937 generator built as a row of word cells.
// Depends on mtg_pkg, mtg_cell and mtg_seed_step.
// Draw: result registered in the cycle after acceptance; one draw per cycle sustained
//   unless the result stalls; each draw twists the head word and shifts it into the tail.
// Seed: one recurrence word per cycle through the seed multiplier; no result.
// Reset: control cleared, then the block seeds itself from 5489 with o_in_ready low.
`default_nettype none
module mersenne_twister_generator_core #(
    parameter int unsigned STATE_DEPTH   = 624,
    parameter int unsigned MIDDLE_OFFSET = 397
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire logic           i_op,
    input  wire mtg_pkg::t_word i_seed_value,
    input  wire mtg_pkg::t_word i_mask,
    output logic                o_out_valid,
    input  wire logic           i_out_ready,
    output mtg_pkg::t_word      o_value
);
    import mtg_pkg::*;

    localparam int unsigned IDX_W = $clog2(STATE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_DEPTH - 1);

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_fill_idx, n_fill_idx;
    logic             r_out_valid;
    t_word            r_value;

    logic  w_accept;
    logic  w_draw;
    logic  w_seed;
    logic  w_shift;
    t_word w_push;
    t_word w_twisted;
    t_word w_seed_next;
    t_word w_q [STATE_DEPTH];

    // input handshake
    assign o_in_ready = (r_state == ST_RUN) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_draw     = w_accept && (t_op'(i_op) == OP_DRAW);
    assign w_seed     = w_accept && (t_op'(i_op) == OP_SEED);

    // row of cells, head at index 0, new words enter at the tail
    for (genvar k = 0; k < STATE_DEPTH; k++) begin : g_cell
        if (k == STATE_DEPTH - 1) begin : g_tail
            mtg_cell #(.WIDTH(WORD_W)) u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_d    (w_push),
                .o_q    (w_q[k])
            );
        end else begin : g_body
            mtg_cell #(.WIDTH(WORD_W)) u_cell (
                .i_clk  (i_clk),
                .i_shift(w_shift),
                .i_d    (w_q[k+1]),
                .o_q    (w_q[k])
            );
        end
    end

    // twist of the head word against its neighbor and the middle tap
    assign w_twisted = f_twist(w_q[0], w_q[1], w_q[MIDDLE_OFFSET]);

    // seeding recurrence from the word last pushed into the tail
    mtg_seed_step #(.IDX_W(IDX_W)) u_seed_step (
        .i_prev (w_q[STATE_DEPTH-1]),
        .i_index(r_fill_idx),
        .o_next (w_seed_next)
    );

    // next state, shift control and tail word
    always_comb begin
        n_state    = r_state;
        n_fill_idx = r_fill_idx;
        w_shift    = 1'b0;
        w_push     = w_twisted;
        unique case (r_state)
            ST_FILL: begin
                w_shift    = 1'b1;
                w_push     = (r_fill_idx == '0) ? RESET_SEED : w_seed_next;
                n_fill_idx = r_fill_idx + IDX_W'(1);
                if (r_fill_idx == LAST_IDX) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_seed) begin
                    w_shift    = 1'b1;
                    w_push     = i_seed_value;
                    n_fill_idx = IDX_W'(1);
                    n_state    = ST_FILL;
                end else if (w_draw) begin
                    w_shift = 1'b1;
                    w_push  = w_twisted;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_FILL;
            r_fill_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_fill_idx <= n_fill_idx;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_draw) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_draw) begin
            r_value <= f_temper(w_twisted) & i_mask;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;

    // checks
    a_seed_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_seed |=> (r_state == ST_FILL) && !o_in_ready)
        else $error("seed transaction did not start a fill");

    a_draw_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_draw |=> o_out_valid)
        else $error("draw transaction produced no result");

    a_fill_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) && (r_fill_idx == LAST_IDX) |=> (r_state == ST_RUN))
        else $error("fill did not end after the last word");

    a_no_output_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FILL) && $past(r_state == ST_FILL) |-> !$rose(o_out_valid))
        else $error("result appeared while filling");

endmodule
`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking regression of mersenne_twister_generator_core (MT19937 draws and seeds).
// Depends on mtg_pkg for the word and op types; carries its own MT19937 predictor.
module testbench;
    import mtg_pkg::t_word;
    import mtg_pkg::t_op;
    import mtg_pkg::OP_DRAW;
    import mtg_pkg::OP_SEED;

    localparam int unsigned MT_DEPTH      = 624;
    localparam int unsigned MT_MIDDLE     = 397;
    localparam t_word       MT_INIT_MULT  = 32'd1812433253;
    localparam t_word       MT_BOOT_SEED  = 32'd5489;
    localparam t_word       MT_MATRIX_A   = 32'h9908_B0DF;
    localparam t_word       MT_TEMPER_B   = 32'h9D2C_5680;
    localparam t_word       MT_TEMPER_C   = 32'hEFC6_0000;
    localparam int unsigned DRAIN_LIMIT   = 20000;
    localparam int unsigned SETTLE_CYCLES = 700;

    logic  i_clk        = 1'b0;
    logic  i_rst_n      = 1'b0;
    logic  i_in_valid   = 1'b0;
    logic  o_in_ready;
    t_op   i_op         = OP_DRAW;
    t_word i_seed_value = '0;
    t_word i_mask       = '0;
    logic  o_out_valid;
    logic  i_out_ready  = 1'b0;
    t_word o_value;

    int unsigned sender_idle_pct    = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned error_count        = 0;

    // predictor state: generator words and read position
    t_word       mt_words [MT_DEPTH];
    int unsigned mt_pos;
    t_word       draw_values_expected [$];

    mersenne_twister_generator_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_seed_value (i_seed_value),
        .i_mask       (i_mask),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_value      (o_value)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("mersenne_twister_generator_core regression: fail");
        $finish;
    end

    // initialization recurrence, marks a twist pending
    function automatic void mt_load_seed(input t_word seed_word);
        t_word prev;
        mt_words[0] = seed_word;
        for (int unsigned k = 1; k < MT_DEPTH; k++) begin
            prev        = mt_words[k-1];
            mt_words[k] = t_word'(MT_INIT_MULT * (prev ^ (prev >> 30))) + t_word'(k);
        end
        mt_pos = MT_DEPTH;
    endfunction

    // full in-place regeneration of the word array
    function automatic void mt_regenerate();
        t_word mixed;
        t_word next_word;
        for (int unsigned k = 0; k < MT_DEPTH; k++) begin
            mixed     = {mt_words[k][31], mt_words[(k + 1) % MT_DEPTH][30:0]};
            next_word = mt_words[(k + MT_MIDDLE) % MT_DEPTH] ^ (mixed >> 1);
            if (mixed[0]) begin
                next_word = next_word ^ MT_MATRIX_A;
            end
            mt_words[k] = next_word;
        end
    endfunction

    function automatic t_word mt_tempered(input t_word raw);
        t_word w;
        w = raw;
        w = w ^ (w >> 11);
        w = w ^ ((w << 7) & MT_TEMPER_B);
        w = w ^ ((w << 15) & MT_TEMPER_C);
        w = w ^ (w >> 18);
        return w;
    endfunction

    // next masked draw value, advancing the predictor
    function automatic t_word mt_next_draw(input t_word mask_word);
        t_word word;
        if (mt_pos >= MT_DEPTH) begin
            mt_regenerate();
            mt_pos = 0;
        end
        word   = mt_tempered(mt_words[mt_pos]);
        mt_pos = mt_pos + 1;
        return word & mask_word;
    endfunction

    initial begin
        mt_load_seed(MT_BOOT_SEED);
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // predict each input transaction, then check each result transaction
    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            if (i_op == OP_SEED) begin
                mt_load_seed(i_seed_value);
            end else begin
                draw_values_expected.push_back(mt_next_draw(i_mask));
            end
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (draw_values_expected.size() == 0) begin
                $error("value: expected none, actual %h", o_value);
                error_count++;
            end else begin
                want = draw_values_expected.pop_front();
                if (o_value !== want) begin
                    $error("value: expected %h, actual %h", want, o_value);
                    error_count++;
                end
            end
        end
    end

    // one input transaction with random idle cycles ahead of it
    task automatic send_item(input t_op op, input t_word seed_word, input t_word mask_word);
        @(negedge i_clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= op;
        i_seed_value <= seed_word;
        i_mask       <= mask_word;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
    endtask

    // sender holds off until every pending draw has returned
    task automatic hold_until_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (draw_values_expected.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic t_word pick_mask();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) return '1;
        if (r < 90) return t_word'($urandom);
        if (r < 95) return '0;
        return t_word'(1) << $urandom_range(31);
    endfunction

    function automatic t_word pick_seed();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return t_word'($urandom);
    endfunction

    // boot seed stream: twist before the first word, masks at the extremes
    task automatic test_boot_stream();
        send_item(OP_DRAW, '0, '1);
        send_item(OP_DRAW, '0, '1);
        send_item(OP_DRAW, '0, '1);
        send_item(OP_DRAW, '1, '0);
        send_item(OP_DRAW, '1, 32'hAAAA_AAAA);
        send_item(OP_DRAW, 32'h5555_5555, 32'h5555_5555);
    endtask

    // seeding: extreme seeds, ignored mask, back-to-back seeds, draw right after a seed
    task automatic test_seed_cases();
        send_item(OP_SEED, '0, '1);
        send_item(OP_DRAW, '0, '1);
        send_item(OP_DRAW, '0, '1);
        send_item(OP_SEED, '1, '0);
        send_item(OP_SEED, 32'h1234_5678, 32'hDEAD_BEEF);
        send_item(OP_DRAW, '1, '1);
        send_item(OP_SEED, MT_BOOT_SEED, '1);
        send_item(OP_DRAW, '0, 32'h0000_0001);
        send_item(OP_DRAW, '0, 32'h8000_0000);
        hold_until_drained();
        send_item(OP_SEED, '1, '1);
        send_item(OP_DRAW, '0, '1);
        send_item(OP_DRAW, 32'hFFFF_0000, 32'h0000_FFFF);
    endtask

    // long stream with no idling, crossing a regeneration boundary
    task automatic test_long_stream(input int unsigned count);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        for (int unsigned n = 0; n < count; n++) begin
            send_item(OP_DRAW, t_word'($urandom), pick_mask());
        end
    endtask

    // random draws with occasional reseeding under a given idling mix
    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct,
                                       input int unsigned count);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int unsigned n = 0; n < count; n++) begin
            if (n == count / 2) begin
                hold_until_drained();
            end
            if ($urandom_range(99) < 4) begin
                send_item(OP_SEED, pick_seed(), t_word'($urandom));
            end else begin
                send_item(OP_DRAW, t_word'($urandom), pick_mask());
            end
        end
    endtask

    initial begin
        int unsigned waited;
        waited = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_boot_stream();
        test_seed_cases();
        test_long_stream(700);
        test_random_traffic(60, 0, 250);
        test_random_traffic(0, 60, 250);
        test_random_traffic(27, 27, 250);

        // drain and settle
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        receiver_stall_pct = 0;
        while (draw_values_expected.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (draw_values_expected.size() != 0) begin
            $error("value: expected %0d more results, actual none", draw_values_expected.size());
            error_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("mersenne_twister_generator_core regression: pass");
        end else begin
            $display("mersenne_twister_generator_core regression: fail");
        end
        $finish;
    end

endmodule
